@@ design/avkf_pkg.sv @@
// ============================================================================
// Altitude/velocity Kalman filter package
// Shared types, micro-program and saturation helpers for the filter unit.
// ============================================================================
package avkf_pkg;

    // Operation codes carried on the operation field.
    localparam logic OPC_PREDICT = 1'b0;
    localparam logic OPC_UPDATE  = 1'b1;

    // Configuration register indexes.
    localparam logic REG_PROCESS_NOISE     = 1'b0;
    localparam logic REG_MEASUREMENT_NOISE = 1'b1;

    // Reset values.
    localparam logic [31:0]        PROCESS_NOISE_RESET     = 32'd16777;
    localparam logic [31:0]        MEASUREMENT_NOISE_RESET = 32'd167772160;
    localparam logic signed [47:0] COV_ONE                 = 48'sh000001000000;

    // Gain divider produces this many quotient bits, one per cycle.
    localparam int DIV_STEPS = 31;

    localparam logic signed [63:0] MAX32_W = 64'sh000000007FFFFFFF;
    localparam logic signed [63:0] MIN32_W = 64'shFFFFFFFF80000000;
    localparam logic signed [63:0] MAX48_W = 64'sh00007FFFFFFFFFFF;
    localparam logic signed [63:0] MIN48_W = 64'shFFFF800000000000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV_CHK,
        ST_DIV_LOOP,
        ST_DIV_END
    } state_t;

    typedef enum logic [2:0] {
        UOP_MUL_LO,
        UOP_MUL_HI,
        UOP_DRAIN,
        UOP_FIN,
        UOP_DIV,
        UOP_EMIT,
        UOP_END
    } uop_t;

    typedef enum logic [2:0] {
        A_DT,
        A_SPEED2,
        A_ACCEL,
        A_COV_SS,
        A_INNER,
        A_Y,
        A_COV_HH,
        A_COV_HS
    } asel_t;

    typedef enum logic [1:0] {
        B_DT,
        B_DT2,
        B_K0,
        B_K1
    } bsel_t;

    typedef enum logic [4:0] {
        D_NONE,
        D_DT2,
        D_HEIGHT_P,
        D_SPEED_P,
        D_SSDT,
        D_INNER,
        D_HH_P,
        D_Y,
        D_K0,
        D_K1,
        D_HEIGHT_U,
        D_SPEED_U,
        D_SH_U,
        D_HH_U,
        D_SS_U,
        D_HS_U
    } dst_t;

    typedef struct packed {
        uop_t  op;
        asel_t a_sel;
        bsel_t b_sel;
        logic  clr;
        dst_t  dst;
    } uinstr_t;

    // Micro-program. Each product takes a low and a high pass through the
    // multiplier, a drain step for the last partial product, then a
    // finishing step that rounds, writes the destination and saturates state.
    function automatic uinstr_t ucode(input logic op, input logic [4:0] pc);
        uinstr_t u;
        u = '{UOP_END, A_DT, B_DT, 1'b0, D_NONE};
        if (op == OPC_PREDICT) begin
            case (pc)
                5'd0:  u = '{UOP_MUL_LO, A_DT,     B_DT,  1'b1, D_NONE};
                5'd1:  u = '{UOP_MUL_HI, A_DT,     B_DT,  1'b0, D_NONE};
                5'd2:  u = '{UOP_DRAIN,  A_DT,     B_DT,  1'b0, D_NONE};
                5'd3:  u = '{UOP_FIN,    A_DT,     B_DT,  1'b0, D_DT2};
                5'd4:  u = '{UOP_MUL_LO, A_SPEED2, B_DT,  1'b1, D_NONE};
                5'd5:  u = '{UOP_MUL_HI, A_SPEED2, B_DT,  1'b0, D_NONE};
                5'd6:  u = '{UOP_MUL_LO, A_ACCEL,  B_DT2, 1'b0, D_NONE};
                5'd7:  u = '{UOP_MUL_HI, A_ACCEL,  B_DT2, 1'b0, D_NONE};
                5'd8:  u = '{UOP_DRAIN,  A_DT,     B_DT,  1'b0, D_NONE};
                5'd9:  u = '{UOP_FIN,    A_DT,     B_DT,  1'b0, D_HEIGHT_P};
                5'd10: u = '{UOP_MUL_LO, A_ACCEL,  B_DT,  1'b1, D_NONE};
                5'd11: u = '{UOP_MUL_HI, A_ACCEL,  B_DT,  1'b0, D_NONE};
                5'd12: u = '{UOP_DRAIN,  A_DT,     B_DT,  1'b0, D_NONE};
                5'd13: u = '{UOP_FIN,    A_DT,     B_DT,  1'b0, D_SPEED_P};
                5'd14: u = '{UOP_MUL_LO, A_COV_SS, B_DT,  1'b1, D_NONE};
                5'd15: u = '{UOP_MUL_HI, A_COV_SS, B_DT,  1'b0, D_NONE};
                5'd16: u = '{UOP_DRAIN,  A_DT,     B_DT,  1'b0, D_NONE};
                5'd17: u = '{UOP_FIN,    A_DT,     B_DT,  1'b0, D_SSDT};
                5'd18: u = '{UOP_FIN,    A_DT,     B_DT,  1'b0, D_INNER};
                5'd19: u = '{UOP_MUL_LO, A_INNER,  B_DT,  1'b1, D_NONE};
                5'd20: u = '{UOP_MUL_HI, A_INNER,  B_DT,  1'b0, D_NONE};
                5'd21: u = '{UOP_DRAIN,  A_DT,     B_DT,  1'b0, D_NONE};
                5'd22: u = '{UOP_FIN,    A_DT,     B_DT,  1'b0, D_HH_P};
                5'd23: u = '{UOP_EMIT,   A_DT,     B_DT,  1'b0, D_NONE};
                default: u = '{UOP_END,  A_DT,     B_DT,  1'b0, D_NONE};
            endcase
        end else begin
            case (pc)
                5'd0:  u = '{UOP_FIN,    A_DT,     B_DT,  1'b0, D_Y};
                5'd1:  u = '{UOP_DIV,    A_DT,     B_DT,  1'b0, D_K0};
                5'd2:  u = '{UOP_DIV,    A_DT,     B_DT,  1'b0, D_K1};
                5'd3:  u = '{UOP_MUL_LO, A_Y,      B_K0,  1'b1, D_NONE};
                5'd4:  u = '{UOP_MUL_HI, A_Y,      B_K0,  1'b0, D_NONE};
                5'd5:  u = '{UOP_DRAIN,  A_DT,     B_DT,  1'b0, D_NONE};
                5'd6:  u = '{UOP_FIN,    A_DT,     B_DT,  1'b0, D_HEIGHT_U};
                5'd7:  u = '{UOP_MUL_LO, A_Y,      B_K1,  1'b1, D_NONE};
                5'd8:  u = '{UOP_MUL_HI, A_Y,      B_K1,  1'b0, D_NONE};
                5'd9:  u = '{UOP_DRAIN,  A_DT,     B_DT,  1'b0, D_NONE};
                5'd10: u = '{UOP_FIN,    A_DT,     B_DT,  1'b0, D_SPEED_U};
                5'd11: u = '{UOP_MUL_LO, A_COV_HH, B_K1,  1'b1, D_NONE};
                5'd12: u = '{UOP_MUL_HI, A_COV_HH, B_K1,  1'b0, D_NONE};
                5'd13: u = '{UOP_DRAIN,  A_DT,     B_DT,  1'b0, D_NONE};
                5'd14: u = '{UOP_FIN,    A_DT,     B_DT,  1'b0, D_SH_U};
                5'd15: u = '{UOP_MUL_LO, A_COV_HH, B_K0,  1'b1, D_NONE};
                5'd16: u = '{UOP_MUL_HI, A_COV_HH, B_K0,  1'b0, D_NONE};
                5'd17: u = '{UOP_DRAIN,  A_DT,     B_DT,  1'b0, D_NONE};
                5'd18: u = '{UOP_FIN,    A_DT,     B_DT,  1'b0, D_HH_U};
                5'd19: u = '{UOP_MUL_LO, A_COV_HS, B_K1,  1'b1, D_NONE};
                5'd20: u = '{UOP_MUL_HI, A_COV_HS, B_K1,  1'b0, D_NONE};
                5'd21: u = '{UOP_DRAIN,  A_DT,     B_DT,  1'b0, D_NONE};
                5'd22: u = '{UOP_FIN,    A_DT,     B_DT,  1'b0, D_SS_U};
                5'd23: u = '{UOP_MUL_LO, A_COV_HS, B_K0,  1'b1, D_NONE};
                5'd24: u = '{UOP_MUL_HI, A_COV_HS, B_K0,  1'b0, D_NONE};
                5'd25: u = '{UOP_DRAIN,  A_DT,     B_DT,  1'b0, D_NONE};
                5'd26: u = '{UOP_FIN,    A_DT,     B_DT,  1'b0, D_HS_U};
                default: u = '{UOP_END,  A_DT,     B_DT,  1'b0, D_NONE};
            endcase
        end
        return u;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > MAX32_W) begin
            r = MAX32_W[31:0];
        end else if (v < MIN32_W) begin
            r = MIN32_W[31:0];
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > MAX48_W) begin
            r = MAX48_W[47:0];
        end else if (v < MIN48_W) begin
            r = MIN48_W[47:0];
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage

@@ design/altitude_velocity_kalman_filter_unit.sv @@
// ============================================================================
// Altitude/velocity Kalman filter unit
// Two-state fixed-point Kalman filter for height and vertical speed, built
// around one shared multiplier and one shared restoring divider step.
// ============================================================================
//
//  Channel | Handshake                    | Word
//  --------+------------------------------+-----------------------------------
//  in      | in_valid / in_stall          | operation, accel_up, step_time,
//          |                              | baro_height
//  out     | out_valid / out_stall        | height_estimate, speed_estimate
//  cfg     | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// A predict word raises out_valid at its emit step, and the next input word
// can be accepted in the cycle after. An update word produces no result word
// and runs two 31-step gain divisions; a saturating gain skips the division
// loop, and a non-positive innovation variance ends the update at its first
// gain division.
// in_stall is high while the block works. A finished result waits in the
// output register, so the next word can be accepted while the previous result
// is still stalled downstream; a predict then holds at its emit step.
// Reset restores the filter state and the noise registers; no clearing pass.
//
// Datapath: a 33x33 signed multiplier is used in two passes per product
// (low 24 bits, then the high part of a 50-bit operand). Partial products
// are registered and summed into an 84-bit accumulator in the cycle after.
// A finishing step rounds the accumulator to nearest, adds it to the target
// state and saturates. The gains K0 and K1 come from a restoring divider
// producing one quotient bit per cycle, with an overflow check up front.
// ============================================================================
module altitude_velocity_kalman_filter_unit (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic signed [31:0] accel_up,
    input  logic        [23:0] step_time,
    input  logic signed [31:0] baro_height,

    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] height_estimate,
    output logic signed [31:0] speed_estimate,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic        [31:0] cfg_data
);

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    avkf_pkg::state_t  state_reg, state_next;
    logic [4:0]        pc_reg, pc_next;
    avkf_pkg::uinstr_t uop;

    // Latched input word.
    logic               op_reg;
    logic signed [31:0] accel_reg;
    logic        [23:0] dt_reg;
    logic signed [31:0] meas_reg;

    // Configuration.
    logic [31:0] pn_reg;
    logic [31:0] mn_reg;

    // Filter state.
    logic signed [31:0] height_reg;
    logic signed [31:0] speed_reg;
    logic signed [47:0] cov_hh_reg;
    logic signed [47:0] cov_hs_reg;
    logic signed [47:0] cov_sh_reg;
    logic signed [47:0] cov_ss_reg;

    // Intermediates.
    logic        [24:0] dt2_reg;
    logic signed [47:0] ssdt_reg;
    logic signed [49:0] inner_reg;
    logic signed [32:0] y_reg;
    logic signed [49:0] s_reg;
    logic signed [31:0] k0_reg;
    logic signed [31:0] k1_reg;

    // Multiplier pipeline and accumulator.
    logic signed [49:0] a_op;
    logic signed [32:0] a_half;
    logic signed [32:0] b_op;
    logic signed [65:0] prod;
    logic signed [65:0] prod_reg;
    logic               prod_vld_reg;
    logic               prod_hi_reg;
    logic               prod_clr_reg;
    logic signed [83:0] prod_ext;
    logic signed [83:0] acc_reg;
    logic signed [83:0] rnd24;
    logic signed [83:0] rnd25;
    logic signed [59:0] r24;
    logic signed [58:0] r25;

    // Divider.
    logic        [47:0] mag_reg;
    logic               neg_reg;
    logic        [47:0] rem_reg;
    logic        [30:0] nbits_reg;
    logic        [30:0] quo_reg;
    logic        [4:0]  cnt_reg;
    logic        [48:0] div_trial;
    logic        [48:0] div_den;
    logic        [48:0] div_diff;
    logic               div_ge;
    logic               div_sat;
    logic signed [47:0] div_num;
    logic signed [31:0] gain;

    // Output register.
    logic               out_valid_reg;
    logic signed [31:0] height_out_reg;
    logic signed [31:0] speed_out_reg;

    logic run;
    logic mul_en;
    logic fin_en;
    logic out_load;
    logic s_nonpos;

    logic signed [63:0] q_w;

    assign uop      = avkf_pkg::ucode(op_reg, pc_reg);
    assign run      = (state_reg == avkf_pkg::ST_RUN);
    assign mul_en   = run && ((uop.op == avkf_pkg::UOP_MUL_LO) ||
                              (uop.op == avkf_pkg::UOP_MUL_HI));
    assign fin_en   = run && (uop.op == avkf_pkg::UOP_FIN);
    assign out_load = run && (uop.op == avkf_pkg::UOP_EMIT) &&
                      (!out_valid_reg || !out_stall);
    assign s_nonpos = s_reg[49] || (s_reg == '0);

    assign in_stall        = (state_reg != avkf_pkg::ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign height_estimate = height_out_reg;
    assign speed_estimate  = speed_out_reg;

    assign q_w = $signed({32'd0, pn_reg});

    // ------------------------------------------------------------------
    // Operand selection and shared multiplier
    // ------------------------------------------------------------------
    always_comb
    begin
        case (uop.a_sel)
            avkf_pkg::A_DT:     a_op = $signed({26'd0, dt_reg});
            avkf_pkg::A_SPEED2: a_op = $signed({{17{speed_reg[31]}}, speed_reg, 1'b0});
            avkf_pkg::A_ACCEL:  a_op = 50'(accel_reg);
            avkf_pkg::A_COV_SS: a_op = 50'(cov_ss_reg);
            avkf_pkg::A_INNER:  a_op = inner_reg;
            avkf_pkg::A_Y:      a_op = 50'(y_reg);
            avkf_pkg::A_COV_HH: a_op = 50'(cov_hh_reg);
            avkf_pkg::A_COV_HS: a_op = 50'(cov_hs_reg);
            default:            a_op = '0;
        endcase
        case (uop.b_sel)
            avkf_pkg::B_DT:  b_op = $signed({9'd0, dt_reg});
            avkf_pkg::B_DT2: b_op = $signed({8'd0, dt2_reg});
            avkf_pkg::B_K0:  b_op = 33'(k0_reg);
            avkf_pkg::B_K1:  b_op = 33'(k1_reg);
            default:         b_op = '0;
        endcase
        // The high pass takes the signed upper part of the operand; its
        // product is weighted by 2^24 when it reaches the accumulator.
        if (uop.op == avkf_pkg::UOP_MUL_HI) begin
            a_half = $signed({{7{a_op[49]}}, a_op[49:24]});
        end else begin
            a_half = $signed({9'd0, a_op[23:0]});
        end
    end

    assign prod     = a_half * b_op;
    assign prod_ext = prod_hi_reg ? (84'(prod_reg) <<< 24) : 84'(prod_reg);

    // Round to nearest, ties upward, at 2^-24 and 2^-25 weight.
    assign rnd24 = acc_reg + 84'sd8388608;
    assign rnd25 = acc_reg + 84'sd16777216;
    assign r24   = $signed(rnd24[83:24]);
    assign r25   = $signed(rnd25[83:25]);

    // ------------------------------------------------------------------
    // Divider step
    // ------------------------------------------------------------------
    assign div_num   = (uop.dst == avkf_pkg::D_K0) ? cov_hh_reg : cov_sh_reg;
    assign div_den   = {1'b0, s_reg[47:0]};
    assign div_trial = {rem_reg, nbits_reg[30]};
    assign div_ge    = (div_trial >= div_den);
    assign div_diff  = div_trial - div_den;
    // A gain of 128 or more does not fit Q7.24 and saturates.
    assign div_sat   = ({7'd0, mag_reg} >= {s_reg[47:0], 7'd0});
    assign gain      = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= avkf_pkg::ST_IDLE;
            pc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            avkf_pkg::ST_IDLE:
            begin
                if (in_valid) begin
                    state_next = avkf_pkg::ST_RUN;
                    pc_next    = '0;
                end
            end
            avkf_pkg::ST_RUN:
            begin
                case (uop.op)
                    avkf_pkg::UOP_DIV:
                    begin
                        // A non-positive innovation variance leaves the
                        // state untouched.
                        state_next = s_nonpos ? avkf_pkg::ST_IDLE : avkf_pkg::ST_DIV_CHK;
                    end
                    avkf_pkg::UOP_EMIT:
                    begin
                        if (out_load) begin
                            state_next = avkf_pkg::ST_IDLE;
                        end
                    end
                    avkf_pkg::UOP_END:
                    begin
                        state_next = avkf_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        pc_next = pc_reg + 5'd1;
                    end
                endcase
            end
            avkf_pkg::ST_DIV_CHK:
            begin
                state_next = div_sat ? avkf_pkg::ST_DIV_END : avkf_pkg::ST_DIV_LOOP;
            end
            avkf_pkg::ST_DIV_LOOP:
            begin
                if (cnt_reg == 5'(avkf_pkg::DIV_STEPS - 1)) begin
                    state_next = avkf_pkg::ST_DIV_END;
                end
            end
            avkf_pkg::ST_DIV_END:
            begin
                state_next = avkf_pkg::ST_RUN;
                pc_next    = pc_reg + 5'd1;
            end
            default:
            begin
                state_next = avkf_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers: configuration, filter state, pipeline valids
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pn_reg        <= avkf_pkg::PROCESS_NOISE_RESET;
            mn_reg        <= avkf_pkg::MEASUREMENT_NOISE_RESET;
            height_reg    <= '0;
            speed_reg     <= '0;
            cov_hh_reg    <= avkf_pkg::COV_ONE;
            cov_hs_reg    <= '0;
            cov_sh_reg    <= '0;
            cov_ss_reg    <= avkf_pkg::COV_ONE;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    avkf_pkg::REG_PROCESS_NOISE:     pn_reg <= cfg_data;
                    avkf_pkg::REG_MEASUREMENT_NOISE: mn_reg <= cfg_data;
                    default:                         pn_reg <= pn_reg;
                endcase
            end

            prod_vld_reg  <= mul_en;
            out_valid_reg <= out_load || (out_valid_reg && out_stall);

            if (fin_en) begin
                case (uop.dst)
                    avkf_pkg::D_HEIGHT_P:
                        height_reg <= avkf_pkg::sat32(64'(height_reg) + 64'(r25));
                    avkf_pkg::D_SPEED_P:
                        speed_reg <= avkf_pkg::sat32(64'(speed_reg) + 64'(r24));
                    avkf_pkg::D_SSDT:
                        cov_ss_reg <= avkf_pkg::sat48(64'(cov_ss_reg) + q_w);
                    avkf_pkg::D_INNER:
                    begin
                        cov_hs_reg <= avkf_pkg::sat48(64'(cov_hs_reg) + 64'(ssdt_reg));
                        cov_sh_reg <= avkf_pkg::sat48(64'(cov_sh_reg) + 64'(ssdt_reg));
                    end
                    avkf_pkg::D_HH_P:
                        cov_hh_reg <= avkf_pkg::sat48(64'(cov_hh_reg) + 64'(r24) + q_w);
                    avkf_pkg::D_HEIGHT_U:
                        height_reg <= avkf_pkg::sat32(64'(height_reg) + 64'(r24));
                    avkf_pkg::D_SPEED_U:
                        speed_reg <= avkf_pkg::sat32(64'(speed_reg) + 64'(r24));
                    avkf_pkg::D_SH_U:
                        cov_sh_reg <= avkf_pkg::sat48(64'(cov_sh_reg) - 64'(r24));
                    avkf_pkg::D_HH_U:
                        cov_hh_reg <= avkf_pkg::sat48(64'(cov_hh_reg) - 64'(r24));
                    avkf_pkg::D_SS_U:
                        cov_ss_reg <= avkf_pkg::sat48(64'(cov_ss_reg) - 64'(r24));
                    avkf_pkg::D_HS_U:
                        cov_hs_reg <= avkf_pkg::sat48(64'(cov_hs_reg) - 64'(r24));
                    default:
                        height_reg <= height_reg;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: input word, intermediates, multiplier, divider
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            op_reg    <= operation;
            accel_reg <= accel_up;
            dt_reg    <= step_time;
            meas_reg  <= baro_height;
        end

        if (mul_en) begin
            prod_reg     <= prod;
            prod_hi_reg  <= (uop.op == avkf_pkg::UOP_MUL_HI);
            prod_clr_reg <= uop.clr;
        end

        if (prod_vld_reg) begin
            acc_reg <= (prod_clr_reg ? 84'sd0 : acc_reg) + prod_ext;
        end

        if (fin_en) begin
            case (uop.dst)
                avkf_pkg::D_DT2:   dt2_reg  <= r24[24:0];
                avkf_pkg::D_SSDT:  ssdt_reg <= r24[47:0];
                avkf_pkg::D_INNER:
                    inner_reg <= $signed({{1{cov_hs_reg[47]}}, cov_hs_reg, 1'b0}) +
                                 50'(ssdt_reg);
                avkf_pkg::D_Y:
                begin
                    y_reg <= 33'(meas_reg) - 33'(height_reg);
                    s_reg <= 50'(cov_hh_reg) + $signed({18'd0, mn_reg});
                end
                default:           dt2_reg <= dt2_reg;
            endcase
        end

        if (out_load) begin
            height_out_reg <= height_reg;
            speed_out_reg  <= speed_reg;
        end

        case (state_reg)
            avkf_pkg::ST_RUN:
            begin
                if (uop.op == avkf_pkg::UOP_DIV) begin
                    mag_reg <= div_num[47] ? 48'(-div_num) : 48'(div_num);
                    neg_reg <= div_num[47];
                end
            end
            avkf_pkg::ST_DIV_CHK:
            begin
                // Quotient bits below the integer part come from the
                // fraction shifted in behind the low bits of the magnitude.
                rem_reg   <= {7'd0, mag_reg[47:7]};
                nbits_reg <= {mag_reg[6:0], 24'd0};
                cnt_reg   <= '0;
                quo_reg   <= div_sat ? '1 : '0;
            end
            avkf_pkg::ST_DIV_LOOP:
            begin
                rem_reg   <= div_ge ? div_diff[47:0] : div_trial[47:0];
                nbits_reg <= {nbits_reg[29:0], 1'b0};
                quo_reg   <= {quo_reg[29:0], div_ge};
                cnt_reg   <= cnt_reg + 5'd1;
            end
            avkf_pkg::ST_DIV_END:
            begin
                if (uop.dst == avkf_pkg::D_K0) begin
                    k0_reg <= gain;
                end else begin
                    k1_reg <= gain;
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

endmodule

@@ verif/altitude_velocity_kalman_filter_unit_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Altitude/velocity Kalman filter unit testbench
// Drives predict and update words into the filter and writes the noise
// registers. A scoreboard class runs its own fixed-point copy of the filter
// and checks every predicted height and speed word in order.
// ============================================================================
module altitude_velocity_kalman_filter_unit_tb;

    localparam longint ONE_Q24  = 64'sd16777216;
    localparam longint MAX48    = 64'sh00007FFFFFFFFFFF;
    localparam longint MIN48    = 64'shFFFF800000000000;
    localparam longint GAIN_MAX = 64'sd2147483647;

    int mismatch_count;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Arithmetic shift right is a floor divide by a power of two.
    function automatic longint fsr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip48(input longint v);
        if (v > MAX48) return MAX48;
        if (v < MIN48) return MIN48;
        return v;
    endfunction

    // Rounded product a*k/2^24, split so that no intermediate overflows.
    function automatic longint rmul(input longint a, input longint k);
        longint hi;
        longint lo;
        hi = fsr(a, 24);
        lo = a - hi * ONE_Q24;
        return hi * k + fsr(lo * k + (ONE_Q24 >>> 1), 24);
    endfunction

    // Gain quotient in Q7.24, truncated toward zero and saturated.
    function automatic longint gain_div(input longint num, input longint den);
        longint unsigned mag;
        longint unsigned d;
        longint unsigned rem;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : num;
        d   = den;
        q   = mag / d;
        rem = mag % d;
        if (q >= 128) begin
            q = GAIN_MAX;
        end else begin
            for (int i = 0; i < 24; i++) begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= d) begin
                    rem = rem - d;
                    q   = q | 1;
                end
            end
            if (q > GAIN_MAX) q = GAIN_MAX;
        end
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    typedef struct {
        logic signed [31:0] height;
        logic signed [31:0] speed;
    } estimate_t;

    class filter_scoreboard;
        longint h, v, phh, phs, psh, pss;
        longint unsigned q_noise, r_noise;
        estimate_t pending[$];

        function void reset_filter();
            h = 0; v = 0; phh = ONE_Q24; phs = 0; psh = 0; pss = ONE_Q24;
            q_noise = 64'(avkf_pkg::PROCESS_NOISE_RESET);
            r_noise = 64'(avkf_pkg::MEASUREMENT_NOISE_RESET);
        endfunction

        function void write_reg(input logic idx, input logic [31:0] data);
            if (idx == avkf_pkg::REG_PROCESS_NOISE) q_noise = 64'(data);
            else if (idx == avkf_pkg::REG_MEASUREMENT_NOISE) r_noise = 64'(data);
        endfunction

        // Advances the filter by one accepted input word.
        function void note_word(input logic op, input logic signed [31:0] acc_in,
                                input logic [23:0] dt_in,
                                input logic signed [31:0] meas);
            longint acc, dt, dt2, sum, ss_dt, inner, o_hs, o_ss;
            longint y, s, k0, k1, p00, p01;
            estimate_t e;
            if (op == avkf_pkg::OPC_PREDICT) begin
                acc = longint'(acc_in);
                dt  = longint'(dt_in);
                dt2 = fsr(dt * dt + (ONE_Q24 >>> 1), 24);
                sum = 2 * v * dt + acc * dt2;
                o_hs = phs; o_ss = pss;
                h = clip32(h + fsr(sum + ONE_Q24, 25));
                v = clip32(v + fsr(acc * dt + (ONE_Q24 >>> 1), 24));
                ss_dt = rmul(o_ss, dt);
                inner = 2 * o_hs + ss_dt;
                phh = clip48(phh + rmul(inner, dt) + longint'(q_noise));
                phs = clip48(o_hs + ss_dt);
                psh = clip48(psh + ss_dt);
                pss = clip48(o_ss + longint'(q_noise));
                e.height = h[31:0];
                e.speed  = v[31:0];
                pending.push_back(e);
            end else begin
                y = longint'(meas) - h;
                s = phh + longint'(r_noise);
                // A non-positive innovation variance leaves the state alone.
                if (s <= 0) return;
                k0 = gain_div(phh, s);
                k1 = gain_div(psh, s);
                h = clip32(h + rmul(y, k0));
                v = clip32(v + rmul(y, k1));
                p00 = phh; p01 = phs;
                phh = clip48(p00 - rmul(p00, k0));
                phs = clip48(p01 - rmul(p01, k0));
                psh = clip48(psh - rmul(p00, k1));
                pss = clip48(pss - rmul(p01, k1));
            end
        endfunction

        task check_word(input logic signed [31:0] hgt,
                        input logic signed [31:0] spd);
            estimate_t e;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected word h=%0d v=%0d", hgt, spd));
                return;
            end
            e = pending.pop_front();
            if (hgt !== e.height)
                report_mismatch($sformatf("height %0d, want %0d", hgt, e.height));
            if (spd !== e.speed)
                report_mismatch($sformatf("speed %0d, want %0d", spd, e.speed));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               operation;
    logic signed [31:0] accel_up;
    logic        [23:0] step_time;
    logic signed [31:0] baro_height;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] height_estimate;
    logic signed [31:0] speed_estimate;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic        [31:0] cfg_data;

    filter_scoreboard sb;
    bit  hold_off_req;   // asks the receiver for one long stall stretch
    bit  quiet_rx;       // receiver stops stalling at random during the drain

    altitude_velocity_kalman_filter_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .accel_up        (accel_up),
        .step_time       (step_time),
        .baro_height     (baro_height),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .height_estimate (height_estimate),
        .speed_estimate  (speed_estimate),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Offers one input word after a random gap and waits for its acceptance.
    // Valid stays high after acceptance; a gap or a pause drops it.
    task automatic send_word(input logic op, input logic signed [31:0] acc,
                             input logic [23:0] dt, input logic signed [31:0] meas,
                             input bit no_gap);
        int gap;
        gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 10) : 0);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        accel_up    <= acc;
        step_time   <= dt;
        baro_height <= meas;
        do @(posedge clk); while (in_stall);
        sb.note_word(op, acc, dt, meas);
    endtask

    // Waits for every expected word, then lets an update finish its work.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random field value with a bias toward the extremes.
    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 65536 * 20) - 65536 * 10;
            default: return $urandom();
        endcase
    endfunction

    // Mostly realistic time steps, sometimes any value.
    function automatic logic [23:0] pick_dt();
        case ($urandom_range(0, 5))
            0: return 24'hFFFFFF;
            1: return 24'($urandom());
            default: return 24'($urandom_range(0, 400000));
        endcase
    endfunction

    task automatic random_phase(input int count);
        logic [31:0] a;
        for (int i = 0; i < count; i++) begin
            a = ($urandom_range(0, 3) == 0) ? pick32() : ($urandom_range(0, 1310720) - 655360);
            if ($urandom_range(0, 2) == 0)
                send_word(avkf_pkg::OPC_UPDATE, '0, '0,
                          ($urandom_range(0, 3) == 0) ? pick32() :
                          32'(sb.h + $urandom_range(0, 131072) - 65536),
                          1'b0);
            else
                send_word(avkf_pkg::OPC_PREDICT, a, pick_dt(), pick32(), 1'b0);
        end
    endtask

    // Receiver: draws a stall length per word, with a long hold-off on request.
    initial
    begin
        int wait_cycles;
        out_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_off_req = 1'b0;
            end
            wait_cycles = (quiet_rx || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
            if (wait_cycles != 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            // The word moves on this edge since stall was low.
            sb.check_word(height_estimate, speed_estimate);
        end
    end

    initial
    begin
        #50ms;
        $display("altitude_velocity_kalman_filter_unit_tb: done, errors");
        $finish;
    end

    initial
    begin
        sb = new();
        sb.reset_filter();
        mismatch_count = 0;
        hold_off_req   = 1'b0;
        quiet_rx       = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operation      = avkf_pkg::OPC_PREDICT;
        accel_up       = '0;
        step_time      = '0;
        baro_height    = '0;
        cfg_valid      = 1'b0;
        cfg_index      = avkf_pkg::REG_PROCESS_NOISE;
        cfg_data       = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset noise settings: field extremes, both
        // operations, and a measurement far enough off to saturate the state.
        send_word(avkf_pkg::OPC_PREDICT, '0, '0, '0, 1'b0);
        send_word(avkf_pkg::OPC_PREDICT, 32'sh7FFFFFFF, 24'hFFFFFF, '0, 1'b0);
        send_word(avkf_pkg::OPC_PREDICT, 32'sh7FFFFFFF, 24'hFFFFFF, '0, 1'b0);
        send_word(avkf_pkg::OPC_PREDICT, 32'sh80000000, 24'hFFFFFF, 32'shFFFFFFFF, 1'b0);
        send_word(avkf_pkg::OPC_UPDATE, 32'shFFFFFFFF, 24'hFFFFFF, 32'sh7FFFFFFF, 1'b0);
        send_word(avkf_pkg::OPC_UPDATE, '0, '0, 32'sh80000000, 1'b0);
        send_word(avkf_pkg::OPC_PREDICT, 32'sh00010000, 24'h000001, '0, 1'b0);
        send_word(avkf_pkg::OPC_UPDATE, '0, '0, '0, 1'b0);
        send_word(avkf_pkg::OPC_PREDICT, -32'sh00098000, 24'h028F5C, '0, 1'b0);
        wait_idle();

        // Zero measurement noise drives the gain toward one; a large gain
        // appears when the height variance dwarfs the noise.
        write_cfg(avkf_pkg::REG_MEASUREMENT_NOISE, 32'd0);
        write_cfg(avkf_pkg::REG_PROCESS_NOISE, 32'hFFFFFFFF);
        for (int i = 0; i < 6; i++)
            send_word(avkf_pkg::OPC_PREDICT, 32'sh00020000, 24'h800000, '0, 1'b0);
        send_word(avkf_pkg::OPC_UPDATE, '0, '0, 32'sh00640000, 1'b0);
        send_word(avkf_pkg::OPC_UPDATE, '0, '0, 32'sh80000000, 1'b0);
        // Repeated predicts with a full second push the covariance to its limit.
        for (int i = 0; i < 5; i++)
            send_word(avkf_pkg::OPC_PREDICT, 32'sh7FFFFFFF, 24'hFFFFFF, '0, 1'b0);
        send_word(avkf_pkg::OPC_UPDATE, '0, '0, '0, 1'b0);
        wait_idle();

        // Fill the block while the receiver holds off, then pause the sender.
        write_cfg(avkf_pkg::REG_PROCESS_NOISE, 32'd0);
        write_cfg(avkf_pkg::REG_MEASUREMENT_NOISE, 32'hFFFFFFFF);
        hold_off_req = 1'b1;
        for (int i = 0; i < 6; i++)
            send_word(avkf_pkg::OPC_PREDICT, pick32(), pick_dt(), '0, 1'b1);
        wait_idle();
        random_phase(500);
        wait_idle();

        write_cfg(avkf_pkg::REG_PROCESS_NOISE, avkf_pkg::PROCESS_NOISE_RESET);
        write_cfg(avkf_pkg::REG_MEASUREMENT_NOISE, avkf_pkg::MEASUREMENT_NOISE_RESET);
        random_phase(500);
        wait_idle();

        write_cfg(avkf_pkg::REG_PROCESS_NOISE, $urandom());
        write_cfg(avkf_pkg::REG_MEASUREMENT_NOISE, $urandom_range(1, 32'h0FFFFFFF));
        random_phase(500);

        quiet_rx = 1'b1;
        wait_idle();
        if (mismatch_count == 0 && sb.pending.size() == 0)
            $display("altitude_velocity_kalman_filter_unit_tb: done, clean");
        else
            $display("altitude_velocity_kalman_filter_unit_tb: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
design/avkf_pkg.sv
design/altitude_velocity_kalman_filter_unit.sv
verif/altitude_velocity_kalman_filter_unit_tb.sv
